// File: hdl/lte_pkg.sv
// ----------------------------------------------------------------------------
// lte_pkg
// Types, codes and sizes shared by the lease table controller and datapath.
// ----------------------------------------------------------------------------
package lte_pkg;

  localparam int LEASE_SLOTS = 32;
  localparam int SLOT_W      = $clog2(LEASE_SLOTS);

  localparam logic [31:0] EXPIRE_WINDOW_RST = 32'd60000000;

  localparam logic [2:0] MODE_REGISTER   = 3'd0;
  localparam logic [2:0] MODE_RENEW      = 3'd1;
  localparam logic [2:0] MODE_RELINQUISH = 3'd2;
  localparam logic [2:0] MODE_BLK_QUERY  = 3'd3;
  localparam logic [2:0] MODE_FILE_QUERY = 3'd4;
  localparam logic [2:0] MODE_SCAN       = 3'd5;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_KEY  = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [62:0] block_key;
    logic [62:0] file_key;
    logic [30:0] version_in;
    logic        safe_write_in;
    logic [62:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        answer;
    logic [62:0] expired_block;
    logic [62:0] expired_file;
    logic [30:0] expired_version;
    logic        expired_safe_write;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [62:0] blk;
    logic [62:0] file;
    logic [30:0] ver;
    logic        sw;
  } slot_info_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
    logic scan_emit_mid;
    logic scan_emit_final;
    logic scan_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode_is_scan;
    logic cnt_last;
    logic best_found;
    logic pend_valid;
    logic out_free;
  } ctrl_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_DECIDE,
    S_COMMIT,
    S_SCAN_END
  } ctrl_state_t;

endpackage

// File: hdl/lte_ctrl.sv
// ----------------------------------------------------------------------------
// lte_ctrl
// Sequencer: slot sweeps, result hand-off and table updates.
// ----------------------------------------------------------------------------
module lte_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lte_pkg::ctrl_sts_t  sts,
  output lte_pkg::ctrl_cmd_t  cmd
);

  lte_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lte_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lte_pkg::S_IDLE: begin
        if (in_valid) state_nxt = lte_pkg::S_SWEEP;
      end
      lte_pkg::S_SWEEP: begin
        if (sts.cnt_last) state_nxt = lte_pkg::S_DRAIN;
      end
      lte_pkg::S_DRAIN: state_nxt = lte_pkg::S_DECIDE;
      lte_pkg::S_DECIDE: begin
        state_nxt = sts.mode_is_scan ? lte_pkg::S_SCAN_END : lte_pkg::S_COMMIT;
      end
      lte_pkg::S_COMMIT: begin
        if (sts.out_free) state_nxt = lte_pkg::S_IDLE;
      end
      lte_pkg::S_SCAN_END: begin
        if (sts.best_found) begin
          if (!sts.pend_valid || sts.out_free) state_nxt = lte_pkg::S_SWEEP;
        end else if (sts.out_free) begin
          state_nxt = lte_pkg::S_IDLE;
        end
      end
      default: state_nxt = lte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      lte_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      lte_pkg::S_SWEEP: cmd.issue = 1'b1;
      lte_pkg::S_COMMIT: cmd.commit = sts.out_free;
      lte_pkg::S_SCAN_END: begin
        if (sts.best_found) begin
          // hold the previous hit until we know it is not the final one
          if (!sts.pend_valid || sts.out_free) begin
            cmd.scan_next     = 1'b1;
            cmd.scan_emit_mid = sts.pend_valid;
          end
        end else begin
          cmd.scan_emit_final = sts.out_free;
        end
      end
      default: cmd = '0;
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit || cmd.scan_emit_mid || cmd.scan_emit_final) |-> sts.out_free)
    else $error("result loaded while output register busy");

  a_load_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == lte_pkg::S_SWEEP))
    else $error("transfer accepted without a sweep");

  a_sweep_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_next |-> sts.mode_is_scan && sts.best_found)
    else $error("scan pass restarted outside a scan");

endmodule

// File: hdl/lte_dpath.sv
// ----------------------------------------------------------------------------
// lte_dpath
// Slot memories, valid bits, sweep evaluation and the result register.
// ----------------------------------------------------------------------------
module lte_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  lte_pkg::in_item_t   in_data,
  input  lte_pkg::ctrl_cmd_t  cmd,
  output lte_pkg::ctrl_sts_t  sts,
  output logic                out_valid,
  input  logic                out_stall,
  output lte_pkg::out_item_t  out_data
);

  localparam int SW = lte_pkg::SLOT_W;

  lte_pkg::slot_info_t info_mem [lte_pkg::LEASE_SLOTS];
  logic [62:0]         exp_mem  [lte_pkg::LEASE_SLOTS];

  logic [31:0]                     window_r;
  lte_pkg::in_item_t               item_r;
  logic [lte_pkg::LEASE_SLOTS-1:0] valid_r;
  logic [SW-1:0]                   cnt_r;
  logic [SW-1:0]                   rd_idx_r;
  logic                            rd_vld_r;
  lte_pkg::slot_info_t             rd_info_r;
  logic [62:0]                     rd_exp_r;

  logic                hit_r, free_found_r, fhit_r;
  logic [SW-1:0]       hit_idx_r, free_idx_r;
  logic [62:0]         hit_exp_r;
  logic                best_found_r, pend_valid_r, prev_found_r;
  lte_pkg::slot_info_t best_r, pend_r;
  logic [62:0]         prev_key_r;

  logic                out_valid_r;
  lte_pkg::out_item_t  out_r, out_nxt;
  logic                out_free, emit;

  logic        slot_v, is_match, is_free, is_fmatch, is_expd, is_cand;
  logic [63:0] exp_sum;
  logic [62:0] new_exp;

  assign exp_sum = {1'b0, item_r.now_time} + {32'd0, window_r};
  assign new_exp = exp_sum[63] ? {63{1'b1}} : exp_sum[62:0];

  assign slot_v    = valid_r[rd_idx_r];
  assign is_match  = rd_vld_r && slot_v && (rd_info_r.blk == item_r.block_key);
  assign is_free   = rd_vld_r && !slot_v;
  assign is_fmatch = rd_vld_r && slot_v && (rd_info_r.file == item_r.file_key);
  assign is_expd   = rd_vld_r && slot_v && (rd_exp_r < item_r.now_time);
  assign is_cand   = is_expd && (!prev_found_r || (rd_info_r.blk > prev_key_r))
                     && (!best_found_r || (rd_info_r.blk < best_r.blk));

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cmd.commit || cmd.scan_emit_mid || cmd.scan_emit_final;

  assign sts.mode_is_scan = (item_r.mode == lte_pkg::MODE_SCAN);
  assign sts.cnt_last     = (cnt_r == SW'(lte_pkg::LEASE_SLOTS - 1));
  assign sts.best_found   = best_found_r;
  assign sts.pend_valid   = pend_valid_r;
  assign sts.out_free     = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= lte_pkg::EXPIRE_WINDOW_RST;
    end else if (cfg_wr_en) begin
      window_r <= cfg_wr_data;
    end
  end

  // slot memories, registered read
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_info_r <= info_mem[cnt_r];
      rd_exp_r  <= exp_mem[cnt_r];
      rd_idx_r  <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && item_r.mode == lte_pkg::MODE_REGISTER && !hit_r && free_found_r) begin
      info_mem[free_idx_r] <= '{blk: item_r.block_key, file: item_r.file_key,
                                ver: item_r.version_in, sw: item_r.safe_write_in};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && item_r.mode == lte_pkg::MODE_REGISTER && !hit_r && free_found_r) begin
      exp_mem[free_idx_r] <= new_exp;
    end else if (cmd.commit && item_r.mode == lte_pkg::MODE_RENEW && hit_r) begin
      exp_mem[hit_idx_r] <= new_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      if (item_r.mode == lte_pkg::MODE_REGISTER && !hit_r && free_found_r) begin
        valid_r[free_idx_r] <= 1'b1;
      end else if (item_r.mode == lte_pkg::MODE_RELINQUISH && hit_r) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.load || cmd.scan_next) begin
      cnt_r <= '0;
    end else if (cmd.issue) begin
      cnt_r <= cnt_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
    end
  end

  // sweep accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      fhit_r       <= 1'b0;
      best_found_r <= 1'b0;
      pend_valid_r <= 1'b0;
      prev_found_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      fhit_r       <= 1'b0;
      best_found_r <= 1'b0;
      pend_valid_r <= 1'b0;
      prev_found_r <= 1'b0;
    end else if (cmd.scan_next) begin
      best_found_r <= 1'b0;
      pend_valid_r <= 1'b1;
      prev_found_r <= 1'b1;
    end else begin
      if (is_match && !hit_r) hit_r <= 1'b1;
      if (is_free && !free_found_r) free_found_r <= 1'b1;
      if (is_fmatch) fhit_r <= 1'b1;
      if (is_cand) best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_match && !hit_r) begin
      hit_idx_r <= rd_idx_r;
      hit_exp_r <= rd_exp_r;
    end
    if (is_free && !free_found_r) free_idx_r <= rd_idx_r;
    if (is_cand && !cmd.scan_next) best_r <= rd_info_r;
    if (cmd.scan_next) begin
      pend_r     <= best_r;
      prev_key_r <= best_r.blk;
    end
  end

  always_comb begin
    out_nxt = '0;
    out_nxt.last = 1'b1;
    if (cmd.commit) begin
      case (item_r.mode)
        lte_pkg::MODE_REGISTER: begin
          if (hit_r) out_nxt.status = lte_pkg::STS_KEY;
          else if (!free_found_r) out_nxt.status = lte_pkg::STS_FULL;
          else out_nxt.status = lte_pkg::STS_OK;
        end
        lte_pkg::MODE_RENEW, lte_pkg::MODE_RELINQUISH: begin
          out_nxt.status = hit_r ? lte_pkg::STS_OK : lte_pkg::STS_KEY;
        end
        lte_pkg::MODE_BLK_QUERY: out_nxt.answer = hit_r && !(hit_exp_r < item_r.now_time);
        lte_pkg::MODE_FILE_QUERY: out_nxt.answer = fhit_r;
        default: out_nxt.status = lte_pkg::STS_OK;
      endcase
    end else if (pend_valid_r) begin
      out_nxt.answer             = 1'b1;
      out_nxt.expired_block      = pend_r.blk;
      out_nxt.expired_file       = pend_r.file;
      out_nxt.expired_version    = pend_r.ver;
      out_nxt.expired_safe_write = pend_r.sw;
      out_nxt.last               = cmd.scan_emit_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hdl/lease_table_with_expiry_core.sv
// ----------------------------------------------------------------------------
// lease_table_with_expiry_core
// Lease table keyed by block id with expiry aging and an expired-entry scan.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one operation per transfer;
// results leave on out_valid/out_stall/out_data, one per transfer, with last
// set on the final result of an operation. One operation is worked at a time:
// in_stall is low only while the sequencer is idle.
// Every operation sweeps all LEASE_SLOTS slots through the slot memories at
// one slot per cycle, then drains the registered read, decides and loads the
// result once the output register has room, then returns to idle.
// A scan repeats the sweep once per expired entry plus a closing one,
// reporting in ascending block id.
// The result register lets the sweep run while a result waits; a stalled
// receiver holds the block only when a new result has to be loaded.
// cfg_wr_en/cfg_wr_data write the lease window; write it only while idle.
// Reset (rst_n low, synchronous) empties the table and restores the window.
// ----------------------------------------------------------------------------
module lease_table_with_expiry_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lte_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lte_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data
);

  lte_pkg::ctrl_cmd_t cmd;
  lte_pkg::ctrl_sts_t sts;

  lte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lte_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// File: tb/sv/lease_checker.sv
// ----------------------------------------------------------------------------
// lease_checker
// Watches both channels of the lease table, predicts every result from its
// own copy of the table and the window, and counts mismatches.
// ----------------------------------------------------------------------------
module lease_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  lte_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  lte_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  output int                 mismatches,
  output int                 pending
);

  localparam logic [62:0] TIME_MAX = {63{1'b1}};

  logic [31:0] window;
  logic        lease_used  [lte_pkg::LEASE_SLOTS];
  logic [62:0] lease_block [lte_pkg::LEASE_SLOTS];
  logic [62:0] lease_file  [lte_pkg::LEASE_SLOTS];
  logic [30:0] lease_ver   [lte_pkg::LEASE_SLOTS];
  logic        lease_sw    [lte_pkg::LEASE_SLOTS];
  logic [62:0] lease_expiry[lte_pkg::LEASE_SLOTS];

  lte_pkg::out_item_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [62:0] expiry_at(logic [62:0] now);
    logic [63:0] sum;
    sum = {1'b0, now} + {32'd0, window};
    return sum > {1'b0, TIME_MAX} ? TIME_MAX : sum[62:0];
  endfunction

  function automatic int slot_of(logic [62:0] key);
    for (int i = 0; i < lte_pkg::LEASE_SLOTS; i++)
      if (lease_used[i] && lease_block[i] == key) return i;
    return -1;
  endfunction

  function automatic lte_pkg::out_item_t single(logic [1:0] st, logic ans);
    lte_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.answer = ans;
    r.last   = 1'b1;
    return r;
  endfunction

  task automatic predict_operation(lte_pkg::in_item_t op);
    int s;
    int prev;
    int best;
    int hits;
    logic hit;
    lte_pkg::out_item_t r;
    s = slot_of(op.block_key);
    case (op.mode)
      lte_pkg::MODE_REGISTER: begin
        if (s >= 0) begin
          expected_results.push_back(single(lte_pkg::STS_KEY, 1'b0));
        end else begin
          best = -1;
          for (int i = lte_pkg::LEASE_SLOTS - 1; i >= 0; i--)
            if (!lease_used[i]) best = i;
          if (best < 0) begin
            expected_results.push_back(single(lte_pkg::STS_FULL, 1'b0));
          end else begin
            lease_used[best]   = 1'b1;
            lease_block[best]  = op.block_key;
            lease_file[best]   = op.file_key;
            lease_ver[best]    = op.version_in;
            lease_sw[best]     = op.safe_write_in;
            lease_expiry[best] = expiry_at(op.now_time);
            expected_results.push_back(single(lte_pkg::STS_OK, 1'b0));
          end
        end
      end
      lte_pkg::MODE_RENEW: begin
        if (s < 0) begin
          expected_results.push_back(single(lte_pkg::STS_KEY, 1'b0));
        end else begin
          lease_expiry[s] = expiry_at(op.now_time);
          expected_results.push_back(single(lte_pkg::STS_OK, 1'b0));
        end
      end
      lte_pkg::MODE_RELINQUISH: begin
        if (s < 0) begin
          expected_results.push_back(single(lte_pkg::STS_KEY, 1'b0));
        end else begin
          lease_used[s] = 1'b0;
          expected_results.push_back(single(lte_pkg::STS_OK, 1'b0));
        end
      end
      lte_pkg::MODE_BLK_QUERY:
        expected_results.push_back(single(lte_pkg::STS_OK,
          s >= 0 && !(lease_expiry[s] < op.now_time)));
      lte_pkg::MODE_FILE_QUERY: begin
        hit = 1'b0;
        for (int i = 0; i < lte_pkg::LEASE_SLOTS; i++)
          if (lease_used[i] && lease_file[i] == op.file_key) hit = 1'b1;
        expected_results.push_back(single(lte_pkg::STS_OK, hit));
      end
      lte_pkg::MODE_SCAN: begin
        prev = -1;
        hits = 0;
        forever begin
          best = -1;
          for (int i = 0; i < lte_pkg::LEASE_SLOTS; i++) begin
            if (!lease_used[i] || !(lease_expiry[i] < op.now_time)) continue;
            if (prev >= 0 && lease_block[i] <= lease_block[prev]) continue;
            if (best < 0 || lease_block[i] < lease_block[best]) best = i;
          end
          if (best < 0) break;
          r = '0;
          r.status             = lte_pkg::STS_OK;
          r.answer             = 1'b1;
          r.expired_block      = lease_block[best];
          r.expired_file       = lease_file[best];
          r.expired_version    = lease_ver[best];
          r.expired_safe_write = lease_sw[best];
          expected_results.push_back(r);
          hits++;
          prev = best;
        end
        if (hits == 0) expected_results.push_back(single(lte_pkg::STS_OK, 1'b0));
        else expected_results[$].last = 1'b1;
      end
      default: expected_results.push_back(single(lte_pkg::STS_OK, 1'b0));
    endcase
  endtask

  always @(posedge clk) begin
    lte_pkg::out_item_t exp_r;
    if (!rst_n) begin
      window <= lte_pkg::EXPIRE_WINDOW_RST;
      for (int i = 0; i < lte_pkg::LEASE_SLOTS; i++) lease_used[i] = 1'b0;
      expected_results.delete();
      mismatches <= 0;
    end else begin
      if (cfg_wr_en) window <= cfg_wr_data;
      if (in_valid && !in_stall) predict_operation(in_data);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transfer: actual %p", out_data);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data !== exp_r) begin
            if (mismatches < 10)
              $display("result mismatch: expected %p actual %p", exp_r, out_data);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives lease operations and window writes into the lease table under
// varying idle and stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUIET_LIMIT = 40000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  lte_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  lte_pkg::out_item_t out_data;
  logic               cfg_wr_en;
  logic [31:0]        cfg_wr_data;
  int                 mismatches;
  int                 pending;

  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int          quiet_cycles;
  logic [62:0] key_pool[8];
  logic [62:0] file_pool[4];
  logic [62:0] clock_now;

  lease_table_with_expiry_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lease_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stalls, held high throughout a hold-off
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [62:0] rand63();
    return 63'({$urandom(), $urandom()});
  endfunction

  // valid stays high after the transfer until the next item or an explicit drop
  task automatic send_item(lte_pkg::in_item_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(logic [2:0] mode, logic [62:0] bkey, logic [62:0] fkey,
                         logic [62:0] now);
    lte_pkg::in_item_t op;
    op.mode          = mode;
    op.block_key     = bkey;
    op.file_key      = fkey;
    op.version_in    = 31'($urandom());
    op.safe_write_in = 1'($urandom_range(1));
    op.now_time      = now;
    send_item(op);
  endtask

  // idle, then one window write
  task automatic set_window(logic [31:0] w);
    while (pending != 0) @(negedge clk);
    repeat (3 * 35 * (lte_pkg::LEASE_SLOTS + 1)) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_ops(int count);
    int k;
    logic [2:0] m;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(7);
      if ($urandom_range(19) == 0) m = 3'($urandom_range(7, 6));
      else m = 3'($urandom_range(5));
      if (m == lte_pkg::MODE_REGISTER && $urandom_range(1)) m = lte_pkg::MODE_REGISTER;
      if ($urandom_range(3) == 0) clock_now = rand63();
      else clock_now = clock_now + 63'($urandom_range(200));
      send_op(m, ($urandom_range(9) == 0) ? rand63() : key_pool[k],
              ($urandom_range(4) == 0) ? rand63() : file_pool[k % 4], clock_now);
    end
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clock_now = 63'd1000;
    for (int i = 0; i < 8; i++) key_pool[i] = rand63();
    for (int i = 0; i < 4; i++) file_pool[i] = rand63();
    key_pool[0] = '0;
    key_pool[1] = '1;
    file_pool[0] = '1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: saturation, conflicts, full table, queries, scans
    send_op(lte_pkg::MODE_REGISTER, key_pool[1], file_pool[0], '1);
    send_op(lte_pkg::MODE_REGISTER, key_pool[1], '0, 63'd5);
    send_op(lte_pkg::MODE_REGISTER, key_pool[0], '0, 63'd5);
    send_op(lte_pkg::MODE_BLK_QUERY, key_pool[1], '0, '1);
    send_op(lte_pkg::MODE_BLK_QUERY, key_pool[0], '0, '1);
    send_op(lte_pkg::MODE_FILE_QUERY, '0, file_pool[0], 63'd0);
    send_op(lte_pkg::MODE_FILE_QUERY, '0, 63'd77, 63'd0);
    send_op(lte_pkg::MODE_RENEW, 63'd12345, '0, 63'd0);
    send_op(lte_pkg::MODE_RENEW, key_pool[0], '0, 63'd0);
    send_op(lte_pkg::MODE_RELINQUISH, 63'd12345, '0, 63'd0);
    send_op(lte_pkg::MODE_SCAN, '0, '0, 63'd0);
    send_op(lte_pkg::MODE_SCAN, '0, '0, '1);
    send_op(3'd6, '1, '1, '1);
    send_op(3'd7, '1, '1, '1);
    for (int i = 0; i < lte_pkg::LEASE_SLOTS; i++)
      send_op(lte_pkg::MODE_REGISTER, 63'(lte_pkg::LEASE_SLOTS - i) << 40, 63'(i), 63'(i));
    send_op(lte_pkg::MODE_SCAN, '0, '0, '1);
    send_op(lte_pkg::MODE_RELINQUISH, key_pool[1], '0, 63'd0);
    send_op(lte_pkg::MODE_RELINQUISH, key_pool[0], '0, 63'd0);
    in_valid <= 1'b0;

    set_window(32'd1);
    send_op(lte_pkg::MODE_REGISTER, key_pool[0], file_pool[1], 63'd0);
    send_op(lte_pkg::MODE_SCAN, '0, '0, '1);
    in_valid <= 1'b0;
    @(negedge clk);

    // long receiver hold-off while the sender keeps going
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      random_ops(10);
    join

    set_window(32'hFFFFFFFF);
    random_ops(25);
    set_window(32'd150);
    send_idle_pct = 67;
    random_ops(50);
    set_window(32'd60);
    send_idle_pct = 0;
    recv_stall_pct = 67;
    random_ops(50);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_ops(45);

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
